>>> design/ohi_pkg.sv
// Shared constants, types and command/status bundles of the hash insert core.
package ohi_pkg;

  localparam int TABLE_DEPTH_DEF = 128;

  localparam int SZ_W      = 8;   // table_size register width
  localparam int VAL_W     = 31;
  localparam int SEL_W     = 7;
  localparam int IDXO_W    = 7;   // reported slot index width
  localparam int DATA_W    = 40;  // tdata width on both channels, padded to bytes
  localparam int OUSER_W   = 2;
  localparam int DIV_STEPS = VAL_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [SZ_W-1:0] TABLE_SIZE_RST = SZ_W'(128);

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  localparam logic PROBE_LINEAR = 1'b0;
  localparam logic PROBE_QUAD   = 1'b1;

  localparam logic REG_TABLE_SIZE = 1'b0;
  localparam logic REG_PROBE_MODE = 1'b1;

  typedef struct packed {
    logic load;
    logic div_step;
    logic probe_step;
    logic rd_req;
    logic rd_cap;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic div_last;
    logic probe_done;
    logic out_free;
  } sts_t;

endpackage

>>> design/ohi_ctrl.sv
// Controller state machine: sequences divide, probe, read and result hand-off.
module ohi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  ohi_pkg::sts_t sts,
  output ohi_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_PROBE = 6'b000100,
    ST_RDREQ = 6'b001000,
    ST_RDCAP = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          // action is only visible in the datapath after load
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.is_read) begin
          state_nxt = ST_RDREQ;
        end else begin
          cmd.div_step = 1'b1;
          if (sts.div_last) begin
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        cmd.probe_step = 1'b1;
        if (sts.probe_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_RDREQ: begin
        cmd.rd_req = 1'b1;
        state_nxt  = ST_RDCAP;
      end
      ST_RDCAP: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/ohi_dp.sv
// Datapath: home-slot divider, probe sequencer, slot store, occupancy and output register.
module ohi_dp #(
  parameter int TABLE_DEPTH = ohi_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ohi_pkg::cmd_t                cmd,
  output ohi_pkg::sts_t                sts,
  input  logic [ohi_pkg::SZ_W-1:0]     eff_size,
  input  logic                         probe_mode,
  input  logic [ohi_pkg::DATA_W-1:0]   in_tdata,
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [ohi_pkg::DATA_W-1:0]   out_tdata,
  output logic [ohi_pkg::OUSER_W-1:0]  out_tuser
);

  // table_size is 8 bits wide, so no more than 255 slots are ever addressed
  localparam int SLOTS = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 255;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SZ_W  = ohi_pkg::SZ_W;
  localparam int VAL_W = ohi_pkg::VAL_W;
  localparam int SEL_W = ohi_pkg::SEL_W;

  logic                    act_r;
  logic [VAL_W-1:0]        val_r;
  logic [VAL_W-1:0]        dshift_r;
  logic [SEL_W-1:0]        sel_r;
  logic [SZ_W-1:0]         rem_r;
  logic [ohi_pkg::DCNT_W-1:0] div_cnt_r;
  logic [SZ_W-1:0]         slot_r;
  logic [SZ_W-1:0]         inc_r;
  logic [SZ_W-1:0]         pcnt_r;
  logic [ohi_pkg::IDXO_W-1:0] res_idx_r;
  logic [VAL_W-1:0]        res_val_r;
  logic                    res_used_r;
  logic                    res_full_r;
  logic                    rd_hit_r;
  logic [VAL_W-1:0]        rdata_r;
  logic [SLOTS-1:0]        occ_r;
  logic [VAL_W-1:0]        mem [SLOTS];
  logic                    out_valid_r;
  logic [ohi_pkg::DATA_W-1:0]  out_data_r;
  logic [ohi_pkg::OUSER_W-1:0] out_user_r;

  logic [SZ_W:0]   eff_w;
  logic [SZ_W:0]   div_tmp;
  logic [SZ_W-1:0] rem_nxt;
  logic            div_last;
  logic [IDX_W-1:0] slot_idx;
  logic            slot_free;
  logic            probe_last;
  logic [SZ_W:0]   slot_sum;
  logic [SZ_W-1:0] slot_adv;
  logic [SZ_W:0]   inc_sum;
  logic [SZ_W-1:0] inc_adv;
  logic [SZ_W-1:0] inc_init;
  logic [SZ_W-1:0] sel_ext;
  logic [IDX_W-1:0] sel_idx;
  logic            rd_hit;
  logic            one_slot;

  assign eff_w    = {1'b0, eff_size};
  assign one_slot = (eff_size == SZ_W'(1));

  // restoring remainder, one dividend bit per cycle, MSB first
  assign div_tmp  = {rem_r, dshift_r[VAL_W-1]};
  assign rem_nxt  = (div_tmp >= eff_w) ? SZ_W'(div_tmp - eff_w) : SZ_W'(div_tmp);
  assign div_last = (div_cnt_r == ohi_pkg::DCNT_W'(ohi_pkg::DIV_STEPS - 1));

  // probe i visits home + inc_0 + .. + inc_{i-1}; inc stays 1 (linear) or grows by 2 (i*i)
  assign slot_idx   = slot_r[IDX_W-1:0];
  assign slot_free  = !occ_r[slot_idx];
  assign probe_last = (pcnt_r == eff_size - SZ_W'(1));
  assign slot_sum   = {1'b0, slot_r} + {1'b0, inc_r};
  assign slot_adv   = (slot_sum >= eff_w) ? SZ_W'(slot_sum - eff_w) : SZ_W'(slot_sum);
  assign inc_sum    = {1'b0, inc_r} + (SZ_W + 1)'(2);
  assign inc_adv    = one_slot ? '0 :
                      ((inc_sum >= eff_w) ? SZ_W'(inc_sum - eff_w) : SZ_W'(inc_sum));
  assign inc_init   = one_slot ? '0 : SZ_W'(1);

  assign sel_ext = {1'b0, sel_r};
  assign sel_idx = sel_ext[IDX_W-1:0];
  assign rd_hit  = (sel_ext < eff_size) && occ_r[sel_idx];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r     <= in_tuser;
      val_r     <= in_tdata[VAL_W-1:0];
      dshift_r  <= in_tdata[VAL_W-1:0];
      sel_r     <= in_tdata[VAL_W +: SEL_W];
      rem_r     <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      dshift_r  <= {dshift_r[VAL_W-2:0], 1'b0};
      div_cnt_r <= div_cnt_r + ohi_pkg::DCNT_W'(1);
      if (div_last) begin
        slot_r <= rem_nxt;
        inc_r  <= inc_init;
        pcnt_r <= '0;
      end
    end
    if (cmd.probe_step) begin
      priority if (slot_free) begin
        res_idx_r  <= ohi_pkg::IDXO_W'(slot_r);
        res_val_r  <= val_r;
        res_used_r <= 1'b1;
        res_full_r <= 1'b0;
      end else if (probe_last) begin
        res_idx_r  <= '0;
        res_val_r  <= '0;
        res_used_r <= 1'b0;
        res_full_r <= 1'b1;
      end else begin
        slot_r <= slot_adv;
        inc_r  <= (probe_mode == ohi_pkg::PROBE_QUAD) ? inc_adv : inc_r;
        pcnt_r <= pcnt_r + SZ_W'(1);
      end
    end
    if (cmd.rd_req) begin
      rd_hit_r <= rd_hit;
    end
    if (cmd.rd_cap) begin
      res_idx_r  <= sel_r;
      res_val_r  <= rd_hit_r ? rdata_r : '0;
      res_used_r <= rd_hit_r;
      res_full_r <= 1'b0;
    end
  end

  // slot store
  always_ff @(posedge clk) begin
    if (cmd.probe_step && slot_free) begin
      mem[slot_idx] <= val_r;
    end
    if (cmd.rd_req) begin
      rdata_r <= mem[sel_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      if (cmd.probe_step && slot_free) begin
        occ_r[slot_idx] <= 1'b1;
      end
      if (cmd.rd_req && rd_hit) begin
        occ_r[sel_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= ohi_pkg::DATA_W'({res_val_r, res_idx_r});
      out_user_r <= {res_full_r, res_used_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign sts.is_read    = (act_r == ohi_pkg::ACT_READ);
  assign sts.div_last   = div_last;
  assign sts.probe_done = slot_free || probe_last;
  assign sts.out_free   = !out_valid_r || out_tready;

endmodule

>>> design/open_addressing_hash_insert_core.sv
// Open-addressing hash table core: config registers, controller and datapath.
//
// Input channel (in_*): one beat per operation. in_tuser selects insert or
// read-and-clear; in_tdata carries the value and the slot to read.
// Output channel (out_*): exactly one result beat per input beat, in order.
// Config port (cfg_*): table_size at 0x0, probe_mode at 0x4, to be written only
// while no operation is in flight; the core itself does not enforce this.
// Insert: home slot = value mod size by a bit-serial remainder unit, then one
// probe per cycle against the occupancy flops, at most size probes. Read-and-clear
// passes the DIV, RDREQ and RDCAP states and reads through the slot RAM read port.
// One operation is in flight at a time; in_tready returns in the same cycle that
// its result appears in the output register.
// Reset clears all occupancy bits at once, size returns to 128, mode to
// linear. A stalled receiver holds the output register; the core then waits
// with a finished result until that register frees up.
module open_addressing_hash_insert_core #(
  parameter int TABLE_DEPTH = ohi_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ohi_pkg::DATA_W-1:0]    in_tdata,   // value[30:0], slot_select[37:31]
  input  logic                          in_tuser,   // action
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ohi_pkg::DATA_W-1:0]    out_tdata,  // slot_index[6:0], slot_value[37:7]
  output logic [ohi_pkg::OUSER_W-1:0]   out_tuser,  // slot_used[0], table_full[1]
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ohi_pkg::APB_AW-1:0]    cfg_paddr,
  input  logic [ohi_pkg::APB_DW-1:0]    cfg_pwdata,
  output logic [ohi_pkg::APB_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  localparam int SLOTS = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 255;
  localparam int SZ_W  = ohi_pkg::SZ_W;

  logic [SZ_W-1:0] table_size_r;
  logic            probe_mode_r;
  logic [SZ_W-1:0] eff_size;
  logic            cfg_wr;
  logic            reg_sel;

  ohi_pkg::cmd_t cmd;
  ohi_pkg::sts_t sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= ohi_pkg::TABLE_SIZE_RST;
      probe_mode_r <= ohi_pkg::PROBE_LINEAR;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        ohi_pkg::REG_TABLE_SIZE: table_size_r <= cfg_pwdata[SZ_W-1:0];
        ohi_pkg::REG_PROBE_MODE: probe_mode_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ohi_pkg::REG_TABLE_SIZE: cfg_prdata = ohi_pkg::APB_DW'(table_size_r);
      ohi_pkg::REG_PROBE_MODE: cfg_prdata = ohi_pkg::APB_DW'(probe_mode_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // size clamped to 1 .. SLOTS
  always_comb begin
    priority if (table_size_r == '0) begin
      eff_size = SZ_W'(1);
    end else if (table_size_r > SZ_W'(SLOTS)) begin
      eff_size = SZ_W'(SLOTS);
    end else begin
      eff_size = table_size_r;
    end
  end

  ohi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ohi_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .eff_size   (eff_size),
    .probe_mode (probe_mode_r),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> design/ohi_chk.sv
// Port-level checker for the hash insert core, bound to the top level.
module ohi_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [ohi_pkg::DATA_W-1:0]    out_tdata,
  input logic [ohi_pkg::OUSER_W-1:0]   out_tuser
);

  // a dropped insert and a stored slot never come together
  a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("table_full and slot_used both set");

  // a full table reports no slot and no value
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata == '0))
    else $error("table_full beat carries data");

  // one operation in flight: no accept right after an accept
  a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result beat changed");

endmodule

bind open_addressing_hash_insert_core ohi_chk u_ohi_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
